// ----- hdl/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 lenient decoder.
package u8u16_pkg;

    // Fixed UTF-16 code units and offsets.
    localparam logic [15:0] REPL_UNIT      = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] SUPP_OFFSET    = 21'h10000;

    // Payload of one input item.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } byte_item_t;

    // Payload of one result item.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        stream_done;
    } unit_item_t;

    // What follows the replacement units of a job.
    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_UNIT = 2'd1,
        TAIL_PAIR = 2'd2
    } tail_kind_t;

    // One classified byte: a run of replacement units, then an optional tail.
    typedef struct packed {
        logic [2:0]  rep_count;
        tail_kind_t  tail_kind;
        logic [20:0] tail_point;
        logic        stream_done;
    } job_t;

    // Number of code units a job expands into.
    function automatic logic [2:0] job_units(job_t job);
        logic [2:0] tail_units;
        unique case (job.tail_kind)
            TAIL_UNIT: tail_units = 3'd1;
            TAIL_PAIR: tail_units = 3'd2;
            default:   tail_units = 3'd0;
        endcase
        return job.rep_count + tail_units;
    endfunction

endpackage

// ----- hdl/u8u16_stream_if.sv -----
// Valid/ready stream interface used for the byte input and the code unit output.
interface u8u16_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ----- hdl/u8u16_front.sv -----
// Front end: accepts bytes, tracks the pending sequence and classifies each byte into a job.
module u8u16_front (
    input  logic               clk,
    input  logic               rst_n,
    u8u16_stream_if.sink       byte_stream,
    input  logic               queue_full,
    output logic               push,
    output u8u16_pkg::job_t    job
);
    import u8u16_pkg::*;

    logic [20:0] point_reg, point_next;
    logic [1:0]  needed_reg, needed_next;
    logic [1:0]  taken_reg, taken_next;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        pending;
    logic        is_cont;
    logic [20:0] gathered;
    logic [1:0]  need_dec;
    logic [1:0]  taken_inc;
    logic [1:0]  lead_extra;
    logic [20:0] lead_bits;
    logic [2:0]  reps;
    tail_kind_t  tail_kind;
    logic [20:0] tail_point;

    assign b        = byte_stream.payload.byte_in;
    assign last     = byte_stream.payload.end_of_buffer;
    assign pending  = (needed_reg != 2'd0);
    assign is_cont  = (b[7:6] == 2'b10);
    assign gathered = {point_reg[14:0], b[5:0]};
    assign need_dec = needed_reg - 2'd1;
    assign taken_inc = taken_reg + 2'd1;

    // Classify the byte against the pending sequence and work out the next state.
    always_comb
    begin
        point_next  = point_reg;
        needed_next = needed_reg;
        taken_next  = taken_reg;
        reps        = 3'd0;
        tail_kind   = TAIL_NONE;
        tail_point  = '0;
        lead_extra  = 2'd0;
        lead_bits   = '0;

        if (pending && is_cont)
        begin
            if (need_dec == 2'd0)
            begin
                // Sequence complete: emit the code point, as a pair above the BMP.
                tail_point  = gathered;
                tail_kind   = (gathered[20:16] != 5'd0) ? TAIL_PAIR : TAIL_UNIT;
                point_next  = '0;
                needed_next = 2'd0;
                taken_next  = 2'd0;
            end
            else if (last)
            begin
                // Truncated at the end: replace the lead and every byte taken.
                reps        = 3'd1 + {1'b0, taken_inc};
                point_next  = '0;
                needed_next = 2'd0;
                taken_next  = 2'd0;
            end
            else
            begin
                point_next  = gathered;
                needed_next = need_dec;
                taken_next  = taken_inc;
            end
        end
        else
        begin
            if (pending)
            begin
                // Bad continuation: replace what was gathered, then treat the byte as a lead.
                reps        = 3'd1 + {1'b0, taken_reg};
                point_next  = '0;
                needed_next = 2'd0;
                taken_next  = 2'd0;
            end

            priority if (b[7] == 1'b0)
            begin
                tail_kind  = TAIL_UNIT;
                tail_point = {13'd0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                lead_extra = 2'd1;
                lead_bits  = {16'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                lead_extra = 2'd2;
                lead_bits  = {17'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                lead_extra = 2'd3;
                lead_bits  = {18'd0, b[2:0]};
            end
            else
            begin
                // Stray continuation or a lead from 0xF8 up.
                reps = reps + 3'd1;
            end

            if (lead_extra != 2'd0)
            begin
                if (last)
                begin
                    reps = reps + 3'd1;
                end
                else
                begin
                    point_next  = lead_bits;
                    needed_next = lead_extra;
                    taken_next  = 2'd0;
                end
            end
        end

        // The last byte of a buffer always leaves the decoder idle.
        if (last)
        begin
            point_next  = '0;
            needed_next = 2'd0;
            taken_next  = 2'd0;
        end
    end

    assign byte_stream.ready = !queue_full;
    assign accept = byte_stream.valid && byte_stream.ready;
    assign push   = accept && ((reps != 3'd0) || (tail_kind != TAIL_NONE));

    always_comb
    begin
        job.rep_count   = reps;
        job.tail_kind   = tail_kind;
        job.tail_point  = tail_point;
        job.stream_done = last;
    end

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg  <= '0;
            needed_reg <= 2'd0;
            taken_reg  <= 2'd0;
        end
        else if (accept)
        begin
            point_reg  <= point_next;
            needed_reg <= needed_next;
            taken_reg  <= taken_next;
        end
    end

    // A surrogate pair only comes from a completed sequence, never after replacements.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && (job.tail_kind == TAIL_PAIR)) |-> (job.rep_count == 3'd0))
        else $error("surrogate pair job carries replacement units");

    // The final byte of a buffer leaves no sequence pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> ((needed_reg == 2'd0) && (taken_reg == 2'd0)))
        else $error("sequence still pending after end of buffer");

endmodule

// ----- hdl/u8u16_queue.sv -----
// Short job queue between the front end and the unit emitter.
module u8u16_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u8u16_pkg::job_t    push_job,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output u8u16_pkg::job_t    head_job
);
    import u8u16_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full       = (count_reg == (PTR_W + 1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("job pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("job popped from an empty queue");

endmodule

// ----- hdl/u8u16_back.sv -----
// Back end: expands each job into UTF-16 code units, one unit per cycle while unit_stream is ready.
module u8u16_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  u8u16_pkg::job_t    head_job,
    output logic               pop,
    u8u16_stream_if.source     unit_stream
);
    import u8u16_pkg::*;

    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    unit_item_t  unit_reg;

    logic [2:0]  total;
    logic [2:0]  tail_pos;
    logic [20:0] offset_point;
    logic [15:0] high_unit;
    logic [15:0] low_unit;
    logic [15:0] unit_value;
    logic        is_last;
    logic        load;

    assign total        = job_units(head_job);
    assign tail_pos     = idx_reg - head_job.rep_count;
    assign offset_point = head_job.tail_point - SUPP_OFFSET;
    assign high_unit    = HIGH_SURR_BASE + {5'd0, offset_point[20:10]};
    assign low_unit     = LOW_SURR_BASE + {6'd0, offset_point[9:0]};
    assign is_last      = (idx_reg == (total - 3'd1));

    // Pick the unit at the current position of the job.
    always_comb
    begin
        if (idx_reg < head_job.rep_count)
        begin
            unit_value = REPL_UNIT;
        end
        else
        begin
            unique case (head_job.tail_kind)
                TAIL_UNIT: unit_value = head_job.tail_point[15:0];
                TAIL_PAIR: unit_value = (tail_pos == 3'd0) ? high_unit : low_unit;
                default:   unit_value = REPL_UNIT;
            endcase
        end
    end

    assign load = head_valid && (!out_valid_reg || unit_stream.ready);
    assign pop  = load && is_last;

    assign unit_stream.valid   = out_valid_reg;
    assign unit_stream.payload = unit_reg;

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg.code_unit   <= unit_value;
            unit_reg.run_last    <= is_last;
            unit_reg.stream_done <= head_job.stream_done;
        end
    end

    // Output valid and position within the current job.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 3'd0 : (idx_reg + 3'd1);
            end
            else if (unit_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) head_valid |-> (idx_reg < total))
        else $error("unit position ran past the end of the job");

endmodule

// ----- hdl/utf8_to_utf16_lenient_decoder_top.sv -----
// Top level of the lenient UTF-8 to UTF-16 decoder.
//
// The decoder takes one UTF-8 byte per cycle on byte_stream while the job queue is not full,
// and delivers UTF-16 code units on unit_stream, one unit per cycle while unit_stream is
// ready. A byte gives zero to four units: nothing while a sequence is still being gathered,
// one unit for ASCII or a finished BMP code point, a surrogate pair for a finished
// supplementary code point, and runs of 0xFFFD where the input is malformed or cut off by
// end_of_buffer. A byte is classified in the cycle it is accepted and placed as a job in a
// four-entry queue; the emitter turns the job at the head into units, one per cycle, behind
// an output register. Input is therefore sustained at one byte per cycle as long as bytes
// average at most one unit each and unit_stream stays ready; a byte that gives n units holds
// the emitter until all n are out, and the queue absorbs such bursts and output stalls. A
// byte's job is registered in the queue and its first unit in the output register. There are
// no checks for overlong forms, encoded surrogates or values above 0x10FFFF.
module utf8_to_utf16_lenient_decoder_top (
    input  logic           clk,
    input  logic           rst_n,
    u8u16_stream_if.sink   byte_stream,
    u8u16_stream_if.source unit_stream
);
    import u8u16_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;
    job_t  push_job;
    job_t  head_job;

    u8u16_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .queue_full  (full),
        .push        (push),
        .job         (push_job)
    );

    u8u16_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u8u16_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .unit_stream (unit_stream)
    );

endmodule

// ----- sim/tb_utf8_to_utf16_lenient_decoder_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the lenient UTF-8 to UTF-16 decoder top level.
module tb_utf8_to_utf16_lenient_decoder_top;
    import u8u16_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    u8u16_stream_if #(.payload_t(byte_item_t)) byte_if ();
    u8u16_stream_if #(.payload_t(unit_item_t)) unit_if ();

    utf8_to_utf16_lenient_decoder_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_stream(byte_if),
        .unit_stream(unit_if)
    );

    // Decoder state as tracked by the predictor.
    logic [20:0] point_acc;
    logic [1:0]  conts_left;
    logic [1:0]  conts_seen;

    // Code units produced by the byte being predicted, and all units still awaited.
    logic [15:0] step_units[$];
    unit_item_t  expected_units[$];
    unit_item_t  oldest_unit;

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    always #2 clk = ~clk;

    // Drop any sequence in progress.
    task automatic clear_sequence();
        point_acc  = '0;
        conts_left = '0;
        conts_seen = '0;
    endtask

    // Add one code unit to the units of the byte being predicted.
    task automatic append_unit(input logic [15:0] u);
        step_units.insert(step_units.size(), u);
    endtask

    // Replace the pending lead and every continuation byte taken so far.
    task automatic flush_pending();
        int k;
        append_unit(REPL_UNIT);
        for (k = 0; k < conts_seen; k++)
            append_unit(REPL_UNIT);
        clear_sequence();
    endtask

    // Work out the code units that one accepted byte gives and queue them.
    task automatic decode_byte(input logic [7:0] b, input logic eob);
        logic        taken_as_cont;
        logic [20:0] offset_point;
        unit_item_t  item;
        int          i;
        step_units.delete();
        taken_as_cont = 1'b0;
        if (conts_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                taken_as_cont = 1'b1;
                point_acc     = {point_acc[14:0], b[5:0]};
                conts_left    = conts_left - 2'd1;
                conts_seen    = conts_seen + 2'd1;
                if (conts_left == 2'd0)
                begin
                    // A finished code point: one unit in the BMP, else a surrogate pair.
                    if (point_acc <= 21'h00FFFF)
                    begin
                        append_unit(point_acc[15:0]);
                    end
                    else
                    begin
                        offset_point = point_acc - SUPP_OFFSET;
                        append_unit(HIGH_SURR_BASE + {5'd0, offset_point[20:10]});
                        append_unit(LOW_SURR_BASE + {6'd0, offset_point[9:0]});
                    end
                    clear_sequence();
                end
                else if (eob)
                begin
                    flush_pending();
                end
            end
            else
            begin
                flush_pending();
            end
        end

        // The byte starts something new: ASCII, a multi-byte lead or a bad lead.
        if (!taken_as_cont)
        begin
            if (b[7] == 1'b0)
            begin
                append_unit({8'd0, b});
            end
            else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
            begin
                if (eob)
                begin
                    append_unit(REPL_UNIT);
                end
                else
                begin
                    conts_seen = 2'd0;
                    if (b[5] == 1'b0)
                    begin
                        point_acc  = {16'd0, b[4:0]};
                        conts_left = 2'd1;
                    end
                    else if (b[4] == 1'b0)
                    begin
                        point_acc  = {17'd0, b[3:0]};
                        conts_left = 2'd2;
                    end
                    else
                    begin
                        point_acc  = {18'd0, b[2:0]};
                        conts_left = 2'd3;
                    end
                end
            end
            else
            begin
                append_unit(REPL_UNIT);
            end
        end

        if (eob)
            clear_sequence();

        for (i = 0; i < step_units.size(); i++)
        begin
            item.code_unit   = step_units[i];
            item.run_last    = (i == step_units.size() - 1);
            item.stream_done = eob;
            expected_units.insert(expected_units.size(), item);
        end
    endtask

    // Offer one byte, idling at random beforehand, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        byte_item_t item;
        item.byte_in       = b;
        item.end_of_buffer = eob;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.payload <= item;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        decode_byte(b, eob);
    endtask

    // Random lead byte for a sequence of the given length.
    function automatic logic [7:0] lead_byte(input int seq_len);
        logic [31:0] r;
        r = $urandom();
        case (seq_len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    // Random continuation byte.
    function automatic logic [7:0] cont_byte();
        logic [31:0] r;
        r = $urandom();
        return {2'b10, r[5:0]};
    endfunction

    // ASCII NUL, every sequence length, a surrogate pair and the largest 4-byte value.
    task automatic test_well_formed();
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    // Stray continuation, bad lead, bad continuation, truncated end, then a lead and ASCII as last bytes.
    task automatic test_malformed();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b1);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h41, 1'b1);
    endtask

    // Mostly well-formed sequences with random content, some cut short, some noise.
    task automatic test_random_stream(input int n_bytes);
        int          sent;
        int          kind;
        int          seq_len;
        int          n_conts;
        int          i;
        logic        eob_at_end;
        logic [31:0] r;
        sent = 0;
        while (sent < n_bytes)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                seq_len    = $urandom_range(1, 4);
                eob_at_end = ($urandom_range(7) == 0);
                send_byte(lead_byte(seq_len), eob_at_end && seq_len == 1);
                for (i = 1; i < seq_len; i++)
                    send_byte(cont_byte(), eob_at_end && i == seq_len - 1);
                sent += seq_len;
            end
            else if (kind < 85)
            begin
                seq_len    = $urandom_range(2, 4);
                n_conts    = $urandom_range(0, seq_len - 2);
                eob_at_end = ($urandom_range(2) == 0);
                send_byte(lead_byte(seq_len), eob_at_end && n_conts == 0);
                for (i = 1; i <= n_conts; i++)
                    send_byte(cont_byte(), eob_at_end && i == n_conts);
                sent += 1 + n_conts;
            end
            else
            begin
                r = $urandom();
                send_byte(r[7:0], $urandom_range(15) == 0);
                sent++;
            end
        end
    endtask

    // Receiver: check each accepted unit against the oldest expectation, stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            unit_if.ready <= 1'b0;
        end
        else
        begin
            if (unit_if.valid && unit_if.ready)
            begin
                if (expected_units.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected unit: code_unit=%h run_last=%b stream_done=%b",
                                 unit_if.payload.code_unit, unit_if.payload.run_last,
                                 unit_if.payload.stream_done);
                end
                else
                begin
                    oldest_unit = expected_units.pop_front();
                    if (unit_if.payload.code_unit !== oldest_unit.code_unit ||
                        unit_if.payload.run_last !== oldest_unit.run_last ||
                        unit_if.payload.stream_done !== oldest_unit.stream_done)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("unit differs: expected %h/%b/%b, got %h/%b/%b",
                                     oldest_unit.code_unit, oldest_unit.run_last,
                                     oldest_unit.stream_done, unit_if.payload.code_unit,
                                     unit_if.payload.run_last, unit_if.payload.stream_done);
                    end
                end
            end
            unit_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if ((byte_if.valid && byte_if.ready) || (unit_if.valid && unit_if.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("utf8_to_utf16_lenient_decoder_top: mismatch");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence.
    initial
    begin
        byte_if.valid   = 1'b0;
        byte_if.payload = '0;
        clear_sequence();
        send_idle_pct = 38;
        recv_idle_pct = 66;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed();
        test_malformed();
        test_random_stream(120);

        send_idle_pct = 66;
        recv_idle_pct = 38;
        test_random_stream(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(110);

        // Let the output side drain, then watch for stray units.
        byte_if.valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_units.size() == 0)
            $display("utf8_to_utf16_lenient_decoder_top: match");
        else
            $display("utf8_to_utf16_lenient_decoder_top: mismatch");
        $finish;
    end

endmodule
